// ===== src/dfq_pkg.sv =====
// Shared constants, codes and types for the duplicate-checking FIFO queue.
package dfq_pkg;

  localparam int DEPTH       = 16;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int ID_W        = 16;
  localparam int ACT_W       = 8;
  localparam int NUM_ACTIONS = 4;
  localparam int ACTS_W      = ACT_W * NUM_ACTIONS;
  localparam int REQ_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH   = 2'd0,
    REQ_POP    = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_DUP   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

// ===== src/dfq_cell.sv =====
// One storage cell of the queue chain: holds an entry and compares its id.
module dfq_cell (
  input  logic                       clk,
  input  dfq_pkg::cell_ctl_t         ctl,
  input  logic                       occupied,
  input  logic [dfq_pkg::ID_W-1:0]   nb_id,
  input  logic [dfq_pkg::ACTS_W-1:0] nb_acts,
  input  logic [dfq_pkg::ID_W-1:0]   new_id,
  input  logic [dfq_pkg::ACTS_W-1:0] new_acts,
  input  logic [dfq_pkg::ID_W-1:0]   cmp_id,
  output logic [dfq_pkg::ID_W-1:0]   id,
  output logic [dfq_pkg::ACTS_W-1:0] acts,
  output logic                       match
);
  import dfq_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      id   <= new_id;
      acts <= new_acts;
    end else if (ctl.shift) begin
      id   <= nb_id;
      acts <= nb_acts;
    end
  end

  assign match = occupied && (id == cmp_id);

endmodule

// ===== src/dedup_fifo_queue.sv =====
// Duplicate-checking FIFO queue built as a chain of storage cells.
// The result of a request is registered and appears in the cycle after its input transfer.
// Throughput: one request per cycle while results are taken; the input stalls
// only while the output register holds a result that has not been taken.
// Pop shifts the whole chain toward the head cell in the same cycle.
// Synchronous reset empties the queue and the output register; entry data is undefined.
module dedup_fifo_queue (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [dfq_pkg::REQ_W-1:0]       req_type,
  input  logic [dfq_pkg::ID_W-1:0]        parcel_id,
  input  logic [dfq_pkg::ACT_W-1:0]       action_0,
  input  logic [dfq_pkg::ACT_W-1:0]       action_1,
  input  logic [dfq_pkg::ACT_W-1:0]       action_2,
  input  logic [dfq_pkg::ACT_W-1:0]       action_3,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [dfq_pkg::STATUS_W-1:0]    status,
  output logic                            found,
  output logic [dfq_pkg::ID_W-1:0]        out_id,
  output logic [dfq_pkg::ACT_W-1:0]       out_action_0,
  output logic [dfq_pkg::ACT_W-1:0]       out_action_1,
  output logic [dfq_pkg::ACT_W-1:0]       out_action_2,
  output logic [dfq_pkg::ACT_W-1:0]       out_action_3,
  output logic [dfq_pkg::COUNT_OUT_W-1:0] entry_count
);
  import dfq_pkg::*;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [ID_W-1:0]   cell_id   [DEPTH+1];
  logic [ACTS_W-1:0] cell_acts [DEPTH+1];
  logic [DEPTH-1:0]  match;
  logic [ACTS_W-1:0] new_acts;
  logic              accept;
  logic              any_match;
  logic              full;
  logic              do_push;
  logic              do_pop;
  status_t           res_status;
  logic              res_found;
  logic [ID_W-1:0]   res_id;
  logic [ACTS_W-1:0] res_acts;
  req_t              req;

  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;
  assign req       = req_t'(req_type);
  assign new_acts  = {action_3, action_2, action_1, action_0};
  assign any_match = |match;
  assign full      = (count == CNT_W'(DEPTH));

  assign cell_id[DEPTH]   = '0;
  assign cell_acts[DEPTH] = '0;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    cell_ctl_t ctl;
    assign ctl.load  = accept && do_push && (count == CNT_W'(k));
    assign ctl.shift = accept && do_pop;

    dfq_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .occupied (CNT_W'(k) < count),
      .nb_id    (cell_id[k+1]),
      .nb_acts  (cell_acts[k+1]),
      .new_id   (parcel_id),
      .new_acts (new_acts),
      .cmp_id   (parcel_id),
      .id       (cell_id[k]),
      .acts     (cell_acts[k]),
      .match    (match[k])
    );
  end

  always_comb begin
    res_status = ST_OK;
    res_found  = 1'b0;
    res_id     = '0;
    res_acts   = '0;
    do_push    = 1'b0;
    do_pop     = 1'b0;
    count_next = count;
    unique case (req)
      REQ_PUSH: begin
        if (any_match) begin
          res_status = ST_DUP;
          res_found  = 1'b1;
        end else if (full) begin
          res_status = ST_FULL;
        end else begin
          do_push    = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      REQ_POP: begin
        if (count == '0) begin
          res_status = ST_EMPTY;
        end else begin
          do_pop     = 1'b1;
          res_id     = cell_id[0];
          res_acts   = cell_acts[0];
          count_next = count - CNT_W'(1);
        end
      end
      REQ_LOOKUP: begin
        res_found = any_match;
      end
      REQ_CLEAR: begin
        count_next = '0;
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else if (accept) begin
      count     <= count_next;
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status       <= res_status;
      found        <= res_found;
      out_id       <= res_id;
      out_action_0 <= res_acts[ACT_W-1:0];
      out_action_1 <= res_acts[2*ACT_W-1:ACT_W];
      out_action_2 <= res_acts[3*ACT_W-1:2*ACT_W];
      out_action_3 <= res_acts[4*ACT_W-1:3*ACT_W];
      entry_count  <= COUNT_OUT_W'(count_next);
    end
  end

endmodule

// ===== src/dfq_checker.sv =====
// Port-level assertions for the duplicate-checking FIFO queue and their bind.
module dfq_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [dfq_pkg::STATUS_W-1:0]    status,
  input logic                            found,
  input logic [dfq_pkg::ID_W-1:0]        out_id,
  input logic [dfq_pkg::COUNT_OUT_W-1:0] entry_count
);
  import dfq_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(out_id)
      && $stable(entry_count))
    else $error("Stalled result changed before its transfer.");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> entry_count == '0 && out_id == '0)
    else $error("Empty status with a nonzero count or id.");

  a_dup_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_DUP |-> found)
    else $error("Duplicate status without found.");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> !found && entry_count == COUNT_OUT_W'(DEPTH))
    else $error("Full status with a count below capacity.");

endmodule

bind dedup_fifo_queue dfq_checker u_dfq_checker (.*);

// ===== tb/dedup_fifo_queue_tb.sv =====
// Self-checking testbench for the duplicate-checking FIFO queue with random stalls.
module dedup_fifo_queue_tb;
  import dfq_pkg::*;

  localparam int RANDOM_ITEMS   = 1650;
  localparam int SEGMENT        = 110;
  localparam int POOL_SIZE      = 24;
  localparam int HOLD_CYCLES    = 64;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef enum logic [2:0] {
    PH_NONE,
    PH_SEND_IDLE,
    PH_RECV_STALL,
    PH_BOTH,
    PH_PRESSURE
  } phase_t;

  typedef struct packed {
    req_t                              kind;
    logic [ID_W-1:0]                   id;
    logic [NUM_ACTIONS-1:0][ACT_W-1:0] act;
    phase_t                            phase;
  } request_t;

  typedef struct packed {
    status_t                           status;
    logic                              found;
    logic [ID_W-1:0]                   id;
    logic [NUM_ACTIONS-1:0][ACT_W-1:0] act;
    logic [COUNT_OUT_W-1:0]            count;
  } queue_result_t;

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   in_valid     = 1'b0;
  logic                   in_stall;
  logic [REQ_W-1:0]       req_type     = '0;
  logic [ID_W-1:0]        parcel_id    = '0;
  logic [ACT_W-1:0]       action_0     = '0;
  logic [ACT_W-1:0]       action_1     = '0;
  logic [ACT_W-1:0]       action_2     = '0;
  logic [ACT_W-1:0]       action_3     = '0;
  logic                   out_valid;
  logic                   out_stall    = 1'b0;
  logic [STATUS_W-1:0]    status;
  logic                   found;
  logic [ID_W-1:0]        out_id;
  logic [ACT_W-1:0]       out_action_0;
  logic [ACT_W-1:0]       out_action_1;
  logic [ACT_W-1:0]       out_action_2;
  logic [ACT_W-1:0]       out_action_3;
  logic [COUNT_OUT_W-1:0] entry_count;

  request_t      pending_requests[$];
  queue_result_t expected_results[$];
  request_t      driven;
  phase_t        cur_phase  = PH_NONE;
  phase_t        prev_phase = PH_NONE;
  int            hold_left  = 0;

  logic [ID_W-1:0]                   model_ids  [DEPTH];
  logic [NUM_ACTIONS-1:0][ACT_W-1:0] model_acts [DEPTH];
  int                                model_head  = 0;
  int                                model_count = 0;
  logic [ID_W-1:0]                   id_pool [POOL_SIZE];

  int errors    = 0;
  int n_reqs    = 0;
  int n_results = 0;
  int n_stored  = 0;
  int n_dup     = 0;
  int n_full    = 0;
  int n_popped  = 0;
  int n_empty   = 0;
  int n_lookup  = 0;
  int n_clear   = 0;

  dedup_fifo_queue u_dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned send_idle_pct(phase_t ph);
    case (ph)
      PH_SEND_IDLE: return 82;
      PH_BOTH:      return 32;
      default:      return 0;
    endcase
  endfunction

  function automatic int unsigned recv_stall_pct(phase_t ph);
    case (ph)
      PH_RECV_STALL: return 82;
      PH_BOTH:       return 32;
      default:       return 0;
    endcase
  endfunction

  function automatic void add_request(req_t kind, logic [ID_W-1:0] id,
                                      logic [ACTS_W-1:0] acts, phase_t ph);
    request_t r;
    r.kind  = kind;
    r.id    = id;
    r.act   = acts;
    r.phase = ph;
    pending_requests.push_back(r);
  endfunction

  function automatic queue_result_t predict_request(request_t r);
    queue_result_t res;
    logic          present;
    int            slot;
    res     = '0;
    present = 1'b0;
    for (int k = 0; k < model_count; k++) begin
      if (model_ids[(model_head + k) % DEPTH] == r.id) present = 1'b1;
    end
    case (r.kind)
      REQ_PUSH: begin
        if (present) begin
          res.status = ST_DUP;
          res.found  = 1'b1;
          n_dup++;
        end else if (model_count >= DEPTH) begin
          res.status = ST_FULL;
          n_full++;
        end else begin
          slot             = (model_head + model_count) % DEPTH;
          model_ids[slot]  = r.id;
          model_acts[slot] = r.act;
          model_count++;
          n_stored++;
        end
      end
      REQ_POP: begin
        if (model_count == 0) begin
          res.status = ST_EMPTY;
          n_empty++;
        end else begin
          res.id      = model_ids[model_head];
          res.act     = model_acts[model_head];
          model_head  = (model_head + 1) % DEPTH;
          model_count--;
          n_popped++;
        end
      end
      REQ_LOOKUP: begin
        res.found = present;
        n_lookup++;
      end
      default: begin
        model_head  = 0;
        model_count = 0;
        n_clear++;
      end
    endcase
    res.count = COUNT_OUT_W'(model_count);
    return res;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    request_t nxt;
    logic     load;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_request(driven));
        n_reqs++;
      end
      if (!in_valid || !in_stall) begin
        load = pending_requests.size() > 0 &&
               $urandom_range(99) >= send_idle_pct(pending_requests[0].phase);
        if (load) begin
          nxt        = pending_requests.pop_front();
          driven     <= nxt;
          req_type   <= nxt.kind;
          parcel_id  <= nxt.id;
          action_0   <= nxt.act[0];
          action_1   <= nxt.act[1];
          action_2   <= nxt.act[2];
          action_3   <= nxt.act[3];
          cur_phase  <= nxt.phase;
        end
        in_valid <= load;
      end
    end
  end

  always @(posedge clk) begin
    queue_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (expected_results.size() == 0) begin
          $display("%0t: result transfer with no request outstanding", $time);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, status);
          check_field("found", want.found, found);
          check_field("out_id", want.id, out_id);
          check_field("out_action_0", want.act[0], out_action_0);
          check_field("out_action_1", want.act[1], out_action_1);
          check_field("out_action_2", want.act[2], out_action_2);
          check_field("out_action_3", want.act[3], out_action_3);
          check_field("entry_count", want.count, entry_count);
        end
      end
      if (cur_phase == PH_PRESSURE && prev_phase != PH_PRESSURE) hold_left = HOLD_CYCLES;
      prev_phase = cur_phase;
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= $urandom_range(99) < recv_stall_pct(cur_phase);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin
    phase_t            ph;
    int unsigned       roll;
    int unsigned       push_lim;
    int unsigned       pop_lim;
    logic [ID_W-1:0]   id;
    logic [ACTS_W-1:0] acts;

    // Directed part: empty queue, extreme fields, duplicates, a full queue and a clear.
    add_request(REQ_POP, '0, '0, PH_NONE);
    add_request(REQ_LOOKUP, '0, '0, PH_NONE);
    add_request(REQ_PUSH, '0, '0, PH_NONE);
    add_request(REQ_PUSH, '1, '1, PH_NONE);
    add_request(REQ_PUSH, '0, 32'hA5C3_0F81, PH_NONE);
    add_request(REQ_LOOKUP, '1, '0, PH_NONE);
    add_request(REQ_POP, '1, '1, PH_NONE);
    for (int k = 1; k < DEPTH; k++) begin
      add_request(REQ_PUSH, ID_W'(16'h5A00 + k), ACTS_W'($urandom), PH_NONE);
    end
    add_request(REQ_PUSH, 16'h1234, '1, PH_NONE);
    add_request(REQ_PUSH, '1, '0, PH_NONE);
    add_request(REQ_CLEAR, '1, '1, PH_NONE);
    add_request(REQ_POP, '0, '0, PH_NONE);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      ph = phase_t'((i / SEGMENT) % 5);
      if (i % SEGMENT == 0) begin
        foreach (id_pool[p]) id_pool[p] = ID_W'($urandom);
      end
      if ((i / SEGMENT) % 2 == 0) begin
        push_lim = 60;
        pop_lim  = 80;
      end else begin
        push_lim = 30;
        pop_lim  = 78;
      end
      roll = $urandom_range(99);
      id   = $urandom_range(99) < 80 ? id_pool[$urandom_range(POOL_SIZE - 1)]
                                     : ID_W'($urandom);
      acts = ACTS_W'($urandom);
      if (roll < push_lim) add_request(REQ_PUSH, id, acts, ph);
      else if (roll < pop_lim) add_request(REQ_POP, id, acts, ph);
      else if (roll < 98) add_request(REQ_LOOKUP, id, acts, ph);
      else add_request(REQ_CLEAR, id, acts, ph);
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);

    $display("Ran %0d requests and %0d results through idle, stall and hold-off phases.",
             n_reqs, n_results);
    $display("Push ok %0d dup %0d full %0d, pop ok %0d empty %0d, lookup %0d, clear %0d.",
             n_stored, n_dup, n_full, n_popped, n_empty, n_lookup, n_clear);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/dfq_pkg.sv
src/dfq_cell.sv
src/dedup_fifo_queue.sv
src/dfq_checker.sv
tb/dedup_fifo_queue_tb.sv
